// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TFD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TFD_ASSERT_SAME(lbl, ante, cons)
`define TFD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/tfd_pkg.sv -----
// Package for the three frame difference motion block: sizes, register codes,
// controller states, command/status structs and small helpers. No dependencies.
`timescale 1ns / 1ps
package tfd_pkg;

    localparam int FRAME_PIXELS   = 4096;
    localparam int MAX_SEPARATION = 4;
    localparam int MAX_CHANNELS   = 4;
    localparam int RING_FRAMES    = 2 * MAX_SEPARATION + 1;
    localparam int PIX_W          = $clog2(FRAME_PIXELS);
    localparam int SLOT_W         = $clog2(RING_FRAMES);
    localparam int ADDR_W         = SLOT_W + PIX_W;
    localparam int MEM_DEPTH      = RING_FRAMES * FRAME_PIXELS;
    localparam int CNT_W          = 13;
    localparam int SQ_W           = 18;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEPARATION = 3'd0,
        CFG_ACTIVE_PIX = 3'd1,
        CFG_CHANNELS   = 3'd2,
        CFG_CHECK_EN   = 3'd3,
        CFG_MAX_FG     = 3'd4,
        CFG_THRESHOLD  = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDA,
        ST_RDB,
        ST_CHAN,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic write_rd_a;
        logic rd_b;
        logic chan_step;
        logic sqrt_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last_chan;
        logic multi;
        logic sqrt_last;
        logic out_free;
    } status_t;

    // ring slot k frames before the newest one
    function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] newest,
                                                    input logic [SLOT_W-1:0] k);
        logic [SLOT_W:0] sum;
        begin
            sum = {1'b0, newest} + (SLOT_W+1)'(RING_FRAMES) - {1'b0, k};
            if (sum >= (SLOT_W+1)'(RING_FRAMES))
                sum = sum - (SLOT_W+1)'(RING_FRAMES);
            slot_back = sum[SLOT_W-1:0];
        end
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        begin
            abs_diff = (a > b) ? a - b : b - a;
        end
    endfunction

endpackage

// ----- rtl/tfd_if.sv -----
// Stream interfaces for pixel words in and mask words out.
// Depends on nothing.
`timescale 1ns / 1ps
interface tfd_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    modport source (output valid, chan0, chan1, chan2, chan3, input ready);
    modport sink (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

interface tfd_mask_if;
    logic        valid;
    logic        ready;
    logic [7:0]  mask_value;
    logic        frame_end;
    logic        frame_rejected;
    logic [12:0] foreground_total;
    modport source (output valid, mask_value, frame_end, frame_rejected,
                    foreground_total, input ready);
    modport sink (input valid, mask_value, frame_end, frame_rejected,
                  foreground_total, output ready);
endinterface

// ----- rtl/tfd_ctrl.sv -----
// Sequencer for one pixel: history write/reads, channel loop, root search, output.
// Depends on tfd_pkg.
`timescale 1ns / 1ps
module tfd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tfd_pkg::status_t status,
    output tfd_pkg::cmd_t    cmd,
    output tfd_pkg::state_t  state
);
    import tfd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_RDA;
                end
            end
            ST_RDA:
            begin
                cmd.write_rd_a = 1'b1;
                state_next     = ST_RDB;
            end
            ST_RDB:
            begin
                cmd.rd_b   = 1'b1;
                state_next = ST_CHAN;
            end
            ST_CHAN:
            begin
                cmd.chan_step = 1'b1;
                if (status.last_chan)
                    state_next = status.multi ? ST_SQRT : ST_DONE;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign state = state_reg;

endmodule

// ----- rtl/tfd_datapath.sv -----
// Datapath: config registers, frame history memory, channel differences,
// square-sum, bit-serial rounded root, frame counters and output register.
// Depends on tfd_pkg.
`timescale 1ns / 1ps
module tfd_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]                     chan0,
    input  logic [7:0]                     chan1,
    input  logic [7:0]                     chan2,
    input  logic [7:0]                     chan3,
    input  tfd_pkg::cmd_t                  cmd,
    output tfd_pkg::status_t               status,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [7:0]                     mask_value,
    output logic                           frame_end,
    output logic                           frame_rejected,
    output logic [12:0]                    foreground_total
);
    import tfd_pkg::*;

    // configuration
    logic [2:0]       sep_reg;
    logic [CNT_W-1:0] active_reg;
    logic [2:0]       nch_reg;
    logic             check_en_reg;
    logic [CNT_W-1:0] max_fg_reg;
    logic [7:0]       thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg      <= 3'd1;
            active_reg   <= CNT_W'(FRAME_PIXELS);
            nch_reg      <= 3'd1;
            check_en_reg <= 1'b0;
            max_fg_reg   <= CNT_W'(FRAME_PIXELS);
            thr_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SEPARATION: sep_reg      <= cfg_data[2:0];
                CFG_ACTIVE_PIX: active_reg   <= cfg_data[CNT_W-1:0];
                CFG_CHANNELS:   nch_reg      <= cfg_data[2:0];
                CFG_CHECK_EN:   check_en_reg <= cfg_data[0];
                CFG_MAX_FG:     max_fg_reg   <= cfg_data[CNT_W-1:0];
                CFG_THRESHOLD:  thr_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // clamped settings
    logic [2:0]       sep_c;
    logic [CNT_W-1:0] active_c;
    logic [2:0]       nch_c;

    always_comb
    begin
        sep_c = sep_reg;
        if (sep_reg == 3'd0)
            sep_c = 3'd1;
        else if (sep_reg > 3'(MAX_SEPARATION))
            sep_c = 3'(MAX_SEPARATION);
        active_c = active_reg;
        if (active_reg == '0)
            active_c = CNT_W'(1);
        else if (active_reg > CNT_W'(FRAME_PIXELS))
            active_c = CNT_W'(FRAME_PIXELS);
        nch_c = nch_reg;
        if (nch_reg == 3'd0)
            nch_c = 3'd1;
        else if (nch_reg > 3'(MAX_CHANNELS))
            nch_c = 3'(MAX_CHANNELS);
    end

    // frame state
    logic [SLOT_W-1:0] newest_reg;
    logic [SLOT_W-1:0] stored_reg;
    logic [PIX_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  tally_reg;

    // per-pixel working registers
    logic [31:0]       word_reg;
    logic [31:0]       a_word_reg;
    logic [31:0]       rd_data_reg;
    logic [ADDR_W-1:0] addr_wr_reg;
    logic [ADDR_W-1:0] addr_a_reg;
    logic [ADDR_W-1:0] addr_b_reg;
    logic              warm_reg;
    logic              last_reg;
    logic              multi_reg;
    logic [1:0]        nch_last_reg;
    logic [1:0]        chan_reg;
    logic [7:0]        d_first_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [2:0]        bit_reg;
    logic [7:0]        root_reg;

    // capture-time address arithmetic
    logic [4:0]        n_full;
    logic [4:0]        n_lim;
    logic [4:0]        two_s;
    logic [SLOT_W-1:0] k_a;

    always_comb
    begin
        two_s  = {1'b0, sep_c, 1'b0};
        n_full = 5'(stored_reg) + 5'd1;
        n_lim  = (n_full > two_s + 5'd1) ? two_s + 5'd1 : n_full;
        k_a    = SLOT_W'(n_lim - 5'd1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            word_reg     <= {chan3, chan2, chan1, chan0};
            addr_wr_reg  <= {newest_reg, pos_reg};
            addr_a_reg   <= {slot_back(newest_reg, k_a), pos_reg};
            addr_b_reg   <= {slot_back(newest_reg, SLOT_W'(sep_c)), pos_reg};
            warm_reg     <= n_lim < two_s;
            last_reg     <= ({1'b0, pos_reg} + 13'd1) >= active_c;
            multi_reg    <= nch_c > 3'd1;
            nch_last_reg <= 2'(nch_c - 3'd1);
        end
    end

    // history memory: one port, used for a write with read A or for read B; read data registered
    logic [31:0] history_mem [0:MEM_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (cmd.write_rd_a)
            history_mem[addr_wr_reg] <= word_reg;
        if (cmd.write_rd_a || cmd.rd_b)
            rd_data_reg <= history_mem[cmd.rd_b ? addr_b_reg : addr_a_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_b)
            a_word_reg <= rd_data_reg;
    end

    // one channel per cycle; rd_data_reg holds B here
    logic [7:0]  ch_a, ch_b, ch_c, ab, d;
    logic [8:0]  sum;
    logic [7:0]  sum_sat;
    logic [15:0] d_sq;

    always_comb
    begin
        ch_a    = a_word_reg[8*chan_reg +: 8];
        ch_b    = rd_data_reg[8*chan_reg +: 8];
        ch_c    = word_reg[8*chan_reg +: 8];
        sum     = {1'b0, abs_diff(ch_a, ch_c)} + {1'b0, abs_diff(ch_c, ch_b)};
        sum_sat = sum[8] ? 8'hFF : sum[7:0];
        ab      = abs_diff(ch_a, ch_b);
        d       = (sum_sat > ab) ? sum_sat - ab : 8'd0;
        d_sq    = d * d;
    end

    // rounded root: largest t with 9*(2t-1)^2 <= 4*sq, one bit a cycle
    logic [7:0]  trial;
    logic [8:0]  odd;
    logic [17:0] odd_sq;
    logic [21:0] nine_sq;
    logic [21:0] four_sum;

    always_comb
    begin
        trial    = root_reg | (8'd1 << bit_reg);
        odd      = {trial, 1'b0} - 9'd1;
        odd_sq   = odd * odd;
        nine_sq  = {odd_sq, 3'b000} + 22'(odd_sq);
        four_sum = {2'b00, sq_reg, 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
            bit_reg  <= 3'd7;
        end
        else
        begin
            if (cmd.capture)
                chan_reg <= '0;
            else if (cmd.chan_step)
                chan_reg <= chan_reg + 2'd1;
            if (cmd.capture)
                bit_reg <= 3'd7;
            else if (cmd.sqrt_step)
                bit_reg <= bit_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sq_reg   <= '0;
            root_reg <= '0;
        end
        else
        begin
            if (cmd.chan_step)
                sq_reg <= sq_reg + SQ_W'(d_sq);
            if (cmd.chan_step && chan_reg == 2'd0)
                d_first_reg <= d;
            if (cmd.sqrt_step && nine_sq <= four_sum)
                root_reg <= trial;
        end
    end

    assign status.last_chan = chan_reg == nch_last_reg;
    assign status.multi     = multi_reg;
    assign status.sqrt_last = bit_reg == 3'd0;
    assign status.out_free  = !out_valid || out_ready;

    // result and frame bookkeeping
    logic [7:0]       mask;
    logic [CNT_W-1:0] tally_new;

    always_comb
    begin
        if (warm_reg)
            mask = '0;
        else
            mask = multi_reg ? root_reg : d_first_reg;
        tally_new = (mask > thr_reg) ? tally_reg + CNT_W'(1) : tally_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= '0;
            stored_reg <= '0;
            pos_reg    <= '0;
            tally_reg  <= '0;
            out_valid  <= 1'b0;
        end
        else
        begin
            if (out_ready)
                out_valid <= 1'b0;
            if (cmd.finish)
            begin
                out_valid <= 1'b1;
                if (last_reg)
                begin
                    tally_reg  <= '0;
                    pos_reg    <= '0;
                    newest_reg <= (newest_reg == SLOT_W'(RING_FRAMES - 1)) ?
                                  '0 : newest_reg + SLOT_W'(1);
                    if (stored_reg < SLOT_W'(RING_FRAMES))
                        stored_reg <= stored_reg + SLOT_W'(1);
                end
                else
                begin
                    tally_reg <= tally_new;
                    pos_reg   <= pos_reg + PIX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            mask_value       <= mask;
            frame_end        <= last_reg;
            frame_rejected   <= last_reg && check_en_reg && !warm_reg &&
                                (tally_new > max_fg_reg);
            foreground_total <= last_reg ? tally_new : '0;
        end
    end

endmodule

// ----- rtl/three_frame_difference_motion.sv -----
// Top level of the three frame difference motion block.
// Depends on tfd_pkg, tfd_if, tfd_ctrl, tfd_datapath, assert_macros.svh.
//
//  channel  | dir | words
//  pixel    | in  | chan0..chan3, valid/ready
//  result   | out | mask_value, frame_end, frame_rejected, foreground_total
//  cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// A pixel passes accept, write with read A, read B, the per-channel loop and, for
// several channels, eight root-search steps, then waits until the output is free;
// the history memory port (write with read A, then read B) and the loop set this.
// History memory is not cleared at reset; no warm-up mask reads it.
// A stalled result holds in the output register; the next pixel is taken meanwhile.
`timescale 1ns / 1ps
module three_frame_difference_motion (
    input  logic                           clk,
    input  logic                           rst_n,
    tfd_pixel_if.sink                      pixel,
    tfd_mask_if.source                     result,
    input  logic                           cfg_we,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tfd_pkg::*;

    cmd_t    cmd;
    status_t status;
    state_t  state;

    tfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_ready (pixel.ready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    tfd_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .chan0            (pixel.chan0),
        .chan1            (pixel.chan1),
        .chan2            (pixel.chan2),
        .chan3            (pixel.chan3),
        .cmd              (cmd),
        .status           (status),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .mask_value       (result.mask_value),
        .frame_end        (result.frame_end),
        .frame_rejected   (result.frame_rejected),
        .foreground_total (result.foreground_total)
    );

`include "assert_macros.svh"

    `TFD_ASSERT_NEXT(a_one_at_a_time, pixel.valid && pixel.ready, !pixel.ready)
    `TFD_ASSERT_SAME(a_reject_at_end, result.valid && result.frame_rejected, result.frame_end)
    `TFD_ASSERT_SAME(a_total_at_end, result.valid && !result.frame_end,
                     result.foreground_total == 13'd0)
    `TFD_ASSERT_SAME(a_finish_free, cmd.finish, state == ST_DONE && status.out_free)

endmodule
